// ===== design/integral_image_stream_macros.svh =====
// Assertion macros for the integral image stream RTL.
`ifndef INTEGRAL_IMAGE_STREAM_MACROS_SVH
`define INTEGRAL_IMAGE_STREAM_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IIS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iis assertion failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iis assertion failed");
`else
`define IIS_ASSERT_IMPL(lbl, ante, cons)
`define IIS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/iis_pkg.sv =====
// Shared constants, types and helpers of the integral image stream.
package iis_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  localparam int NumChan = 3;
  localparam int PixW    = 8;
  localparam int SumW    = 32;
  localparam int DimW    = 13;
  localparam int ColW    = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int RowW    = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  // Row sum never exceeds MaxWidth * 255.
  localparam int AccW    = $clog2(MaxWidth * 255 + 1);
  localparam int CfgAddrW = 1;

  localparam logic [CfgAddrW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgAddrW-1:0] RegImageHeight = 1'b1;

  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  typedef logic [NumChan-1:0][PixW-1:0] pix_t;
  typedef logic [NumChan-1:0][AccW-1:0] acc_t;
  typedef logic [NumChan-1:0][SumW-1:0] sums_t;

  // Everything the sum stage needs from the raster scan for one pixel.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            top_row;
    logic            row_end;
    logic            frame_end;
    acc_t            acc;
  } scan_t;

  // Last valid index for a dimension register: zero acts as one, large values clamp.
  function automatic logic [ColW-1:0] width_last(logic [DimW-1:0] v);
    logic [ColW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MaxWidth) begin
      r = ColW'(MaxWidth - 1);
    end else begin
      r = ColW'(v - DimW'(1));
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] height_last(logic [DimW-1:0] v);
    logic [RowW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > MaxHeight) begin
      r = RowW'(MaxHeight - 1);
    end else begin
      r = RowW'(v - DimW'(1));
    end
    return r;
  endfunction

endpackage

// ===== design/iis_line_ram.sv =====
// Simple dual-port line store with registered read data.
module iis_line_ram #(
  parameter int DataW = 96,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-before-write on a same-address collision; the caller forwards.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/iis_scan_ctrl.sv =====
// Raster position, frame size registers and running row sums.
module iis_scan_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [iis_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [iis_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                         accept_i,
  input  iis_pkg::pix_t                pix_i,
  output iis_pkg::scan_t               scan_o
);

  logic [iis_pkg::DimW-1:0] width_q, height_q;
  logic [iis_pkg::ColW-1:0] col_q, col_d;
  logic [iis_pkg::RowW-1:0] row_q, row_d;
  iis_pkg::acc_t            acc_q, acc_d, acc_new;
  logic                     last_col, last_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iis_pkg::WidthReset;
      height_q <= iis_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        iis_pkg::RegImageWidth:  width_q  <= cfg_wdata_i;
        iis_pkg::RegImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < iis_pkg::NumChan; i++) begin
      acc_new[i] = acc_q[i] + iis_pkg::AccW'(pix_i[i]);
    end
    last_col   = col_q >= iis_pkg::width_last(width_q);
    last_frame = last_col && (row_q >= iis_pkg::height_last(height_q));

    col_d = col_q;
    row_d = row_q;
    acc_d = acc_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        acc_d = '0;
        row_d = last_frame ? '0 : row_q + iis_pkg::RowW'(1);
      end else begin
        col_d = col_q + iis_pkg::ColW'(1);
        acc_d = acc_new;
      end
    end

    scan_o.col       = col_q;
    scan_o.top_row   = (row_q == '0);
    scan_o.row_end   = last_col;
    scan_o.frame_end = last_frame;
    scan_o.acc       = acc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      acc_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/iis_sum_pipe.sv =====
// Line store read-modify-write, same-column forwarding and output register.
`include "integral_image_stream_macros.svh"

module iis_sum_pipe (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  iis_pkg::scan_t scan_i,
  output logic           ready_o,
  input  logic           m_ready_i,
  output logic           m_valid_o,
  output iis_pkg::sums_t m_sums_o,
  output logic           m_row_end_o,
  output logic           m_frame_end_o
);

  localparam int WordW = iis_pkg::NumChan * iis_pkg::SumW;

  iis_pkg::scan_t s1_q;
  logic           s1_valid_q, s1_valid_d;
  logic           fwd_q, fwd_d;
  iis_pkg::sums_t fwd_data_q;
  logic           out_valid_q, out_valid_d;
  iis_pkg::sums_t out_sums_q;
  logic           out_row_end_q, out_frame_end_q;

  logic             s1_adv;
  logic [WordW-1:0] rd_word;
  iis_pkg::sums_t   above, sums;

  iis_line_ram #(
    .DataW(WordW),
    .Depth(iis_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_q.col),
    .wdata_i(WordW'(sums)),
    .re_i   (accept_i),
    .raddr_i(scan_i.col),
    .rdata_o(rd_word)
  );

  assign s1_adv  = s1_valid_q && (!out_valid_q || m_ready_i);
  assign ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    // Top row sees zero above; a width-one image hits the column just written.
    if (s1_q.top_row) begin
      above = '0;
    end else if (fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = iis_pkg::sums_t'(rd_word);
    end
    for (int i = 0; i < iis_pkg::NumChan; i++) begin
      sums[i] = above[i] + iis_pkg::SumW'(s1_q.acc[i]);
    end

    s1_valid_d = s1_valid_q;
    fwd_d      = fwd_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
      fwd_d      = s1_adv && (s1_q.col == scan_i.col);
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
      fwd_d      = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q       <= scan_i;
      fwd_data_q <= sums;
    end
    if (s1_adv) begin
      out_sums_q      <= sums;
      out_row_end_q   <= s1_q.row_end;
      out_frame_end_q <= s1_q.frame_end;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign m_sums_o      = out_sums_q;
  assign m_row_end_o   = out_row_end_q;
  assign m_frame_end_o = out_frame_end_q;

  `IIS_ASSERT_IMPL(a_fwd_needs_item, fwd_q, s1_valid_q)
  `IIS_ASSERT_IMPL(a_frame_end_ends_row, out_valid_q && out_frame_end_q, out_row_end_q)
  `IIS_ASSERT_IMPL(a_ready_when_out_free, !out_valid_q, ready_o)
  `IIS_ASSERT_NEXT(a_s1_holds_when_blocked, s1_valid_q && !s1_adv, s1_valid_q)

endmodule

// ===== design/integral_image_stream.sv =====
// Streaming summed-area table for three-channel 8-bit pixels in raster order.
// Takes one pixel per clock with no bubbles while the sum side keeps up; each result
// passes through the read stage register and then the output register before it is
// offered on m_axis_tvalid_o. A stalled sum side holds two pixels (read stage and
// output register) before s_axis_tready_o drops; tready follows m_axis_tready_i
// combinationally. The per-pixel work is a read of the previous row's sums from one
// line store word at the pixel's column, three 32-bit adds and a write back of that
// word, with the next pixel's read overlapping the write; a width-one image, where
// consecutive pixels share a column, is served by forwarding. The line store needs
// no clearing after reset since the top row ignores what it reads. Size registers
// (index 0: width, index 1: height; 0 acts as 1) should be written between frames.
module integral_image_stream (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [23:0]                  s_axis_tdata_i,  // blue_value, green_value, red_value
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [95:0]                  m_axis_tdata_o,  // blue_sum, green_sum, red_sum
  output logic                         m_axis_tlast_o,  // row_end
  output logic                         m_axis_tuser_o,  // frame_end
  input  logic                         cfg_we_i,
  input  logic [iis_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [iis_pkg::DimW-1:0]     cfg_wdata_i
);

  logic           accept;
  iis_pkg::scan_t scan;
  iis_pkg::sums_t sums;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  iis_scan_ctrl u_scan_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .pix_i      (iis_pkg::pix_t'(s_axis_tdata_i)),
    .scan_o     (scan)
  );

  iis_sum_pipe u_sum_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .scan_i       (scan),
    .ready_o      (s_axis_tready_o),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_o    (m_axis_tvalid_o),
    .m_sums_o     (sums),
    .m_row_end_o  (m_axis_tlast_o),
    .m_frame_end_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = 96'(sums);

endmodule
